>>> rtl/core/hift_pkg.sv
// hift_pkg: shared types, codes and constants of the header index flow tracker
// depends on nothing
`default_nettype none
package hift_pkg;
	localparam int MaxFlowsDefault = 256;
	localparam logic [7:0] StaticEntriesReset = 8'd61;

	localparam logic [2:0] KIND_STATIC = 3'd0;
	localparam logic [2:0] KIND_DYN    = 3'd1;
	localparam logic [2:0] KIND_INC    = 3'd2;
	localparam logic [2:0] KIND_SKIP   = 3'd3;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_FEW        = 3'd1;
	localparam logic [2:0] ST_NOT_TWO    = 3'd2;
	localparam logic [2:0] ST_FIRST_BAD  = 3'd3;
	localparam logic [2:0] ST_SECOND_BAD = 3'd4;
	localparam logic [2:0] ST_FULL       = 3'd5;

	typedef struct packed {
		logic [7:0]  header_count;
		logic [2:0]  kind_0;
		logic [15:0] index_0;
		logic [2:0]  kind_1;
		logic [15:0] index_1;
		logic [2:0]  kind_2;
		logic [15:0] index_2;
		logic [2:0]  kind_3;
		logic [15:0] index_3;
		logic [7:0]  extra_inserts;
	} hdr_item_t;

	typedef struct packed {
		logic [7:0] flow_id;
		logic       is_new;
		logic [2:0] status;
	} flow_res_t;

	// classified job handed from front to back
	typedef struct packed {
		logic [2:0]  err;      // ST_OK when a lookup is needed
		logic [1:0]  shift;
		logic [31:0] key_a;    // live indices, offset not yet removed
		logic [31:0] key_b;
		logic [7:0]  extra;    // inserts after the lookup
	} flow_job_t;
endpackage
`default_nettype wire

>>> rtl/core/hift_if.sv
// hift_if: valid/ready channel interface carrying a payload of type T
// depends on nothing; its instances take their payload types from hift_pkg
`default_nettype none
interface hift_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/hift_ram.sv
// hift_ram: generic single-port write, single read port ram with registered read
// no dependencies
`default_nettype none
module hift_ram #(
	parameter int Width = 32,
	parameter int Depth = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> rtl/core/hift_front.sv
// hift_front: classifies one header block into a lookup job, one-entry queue out
// depends on hift_pkg
`default_nettype none
module hift_front import hift_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  static_entries,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire hdr_item_t   item,
	output logic             job_valid,
	input  wire logic        job_ready,
	output flow_job_t        job
);
	logic      full_q;
	flow_job_t job_q;
	flow_job_t job_c;
	logic [2:0]  kinds [4];
	logic [15:0] idxs [4];
	logic [2:0]  k0, k1;
	logic [15:0] i0, i1;
	logic [2:0]  nrel;
	logic        rel;
	logic [31:0] s32;

	assign kinds[0] = item.kind_0; assign idxs[0] = item.index_0;
	assign kinds[1] = item.kind_1; assign idxs[1] = item.index_1;
	assign kinds[2] = item.kind_2; assign idxs[2] = item.index_2;
	assign kinds[3] = item.kind_3; assign idxs[3] = item.index_3;
	assign s32 = {24'd0, static_entries};

	always_comb begin
		nrel = 3'd0; k0 = KIND_STATIC; k1 = KIND_STATIC; i0 = '0; i1 = '0;
		for (int k = 0; k < 4; k++) begin
			rel = (kinds[k] != KIND_STATIC) && (kinds[k] != KIND_SKIP);
			if (rel) begin
				if (nrel == 3'd0) begin k0 = kinds[k]; i0 = idxs[k]; end
				else if (nrel == 3'd1) begin k1 = kinds[k]; i1 = idxs[k]; end
				nrel = nrel + 3'd1;
			end
		end
		job_c.err   = ST_OK;
		job_c.shift = 2'd0;
		job_c.key_a = {16'd0, i0};
		job_c.key_b = {16'd0, i1};
		job_c.extra = (item.header_count > 8'd4) ? item.extra_inserts : 8'd0;
		priority if (item.header_count < 8'd4) job_c.err = ST_FEW;
		else if (nrel != 3'd2) job_c.err = ST_NOT_TWO;
		else if (k0 != KIND_DYN && k0 != KIND_INC) job_c.err = ST_FIRST_BAD;
		else if (k1 != KIND_DYN && k1 != KIND_INC) job_c.err = ST_SECOND_BAD;
		else if (k0 == KIND_DYN && k1 == KIND_DYN) job_c.shift = 2'd0;
		else if (k0 == KIND_DYN) begin
			job_c.shift = 2'd1; job_c.key_a = {16'd0, i0} + 32'd1; job_c.key_b = s32 + 32'd1;
		end else if (k1 == KIND_DYN) begin
			job_c.shift = 2'd1; job_c.key_a = s32 + 32'd1;
		end else begin
			job_c.shift = 2'd2; job_c.key_a = s32 + 32'd2; job_c.key_b = s32 + 32'd1;
		end
	end

	assign in_ready  = !full_q || job_ready;
	assign job_valid = full_q;
	assign job       = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) full_q <= 1'b0;
		else if (in_valid && in_ready) full_q <= 1'b1;
		else if (job_ready) full_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) job_q <= job_c;
	end
endmodule
`default_nettype wire

>>> rtl/core/hift_back.sv
// hift_back: sequential key search over the flow store, insert, offset update
// depends on hift_pkg and hift_ram
`default_nettype none
module hift_back import hift_pkg::*; #(
	parameter int MaxFlows = MaxFlowsDefault
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      job_valid,
	output logic           job_ready,
	input  wire flow_job_t job,
	output logic           res_valid,
	input  wire logic      res_ready,
	output flow_res_t      res
);
	localparam int AW = $clog2(MaxFlows);
	localparam int CW = $clog2(MaxFlows + 1);
	localparam logic [1:0] S_IDLE = 2'd0, S_READ = 2'd1, S_CMP = 2'd2, S_DONE = 2'd3;

	logic [1:0]    state_q;
	logic [CW-1:0] used_q, ptr_q;
	logic [31:0]   offset_q, a_q, b_q;
	logic [7:0]    extra_q;
	logic          res_full_q;
	flow_res_t     res_q;
	logic [31:0]   rd_a, rd_b, off_new;
	logic          we;
	logic [AW-1:0] raddr;

	assign off_new   = offset_q + {30'd0, job.shift};
	assign job_ready = (state_q == S_IDLE) && !res_full_q;
	assign res_valid = res_full_q;
	assign res       = res_q;
	assign raddr     = ptr_q[AW-1:0];
	assign we        = (state_q == S_CMP) && (ptr_q == used_q) && (used_q != CW'(MaxFlows));

	hift_ram #(.Width(32), .Depth(MaxFlows)) u_ram_a (
		.clk(clk), .we(we), .waddr(used_q[AW-1:0]), .wdata(a_q), .raddr(raddr), .rdata(rd_a));
	hift_ram #(.Width(32), .Depth(MaxFlows)) u_ram_b (
		.clk(clk), .we(we), .waddr(used_q[AW-1:0]), .wdata(b_q), .raddr(raddr), .rdata(rd_b));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; used_q <= '0; ptr_q <= '0; offset_q <= '0; res_full_q <= 1'b0;
		end else begin
			if (res_full_q && res_ready) res_full_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (job_valid && job_ready) begin
						if (job.err != ST_OK) begin
							res_q <= '{flow_id: 8'd0, is_new: 1'b0, status: job.err};
							res_full_q <= 1'b1;
						end else begin
							offset_q <= off_new;
							a_q <= job.key_a - off_new;
							b_q <= job.key_b - off_new;
							extra_q <= job.extra;
							ptr_q <= '0;
							state_q <= S_READ;
						end
					end
				end
				S_READ: state_q <= S_CMP;
				S_CMP: begin
					if (ptr_q == used_q) begin
						if (used_q == CW'(MaxFlows))
							res_q <= '{flow_id: 8'd0, is_new: 1'b0, status: ST_FULL};
						else begin
							res_q <= '{flow_id: 8'(used_q), is_new: 1'b1, status: ST_OK};
							used_q <= used_q + 1'b1;
						end
						state_q <= S_DONE;
					end else if (rd_a == a_q && rd_b == b_q) begin
						res_q <= '{flow_id: 8'(ptr_q), is_new: 1'b0, status: ST_OK};
						state_q <= S_DONE;
					end else begin
						ptr_q <= ptr_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_DONE: begin
					offset_q <= offset_q + {24'd0, extra_q};
					res_full_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/hpack_index_flow_tracker_core.sv
// hpack_index_flow_tracker_core: top level of the header index flow tracker
// depends on hift_pkg, hift_if, hift_front, hift_back, hift_ram
//
// channel | dir | payload
// in      | in  | hdr_item_t: header count, four kind/index pairs, extra inserts
// out     | out | flow_res_t: flow_id, is_new, status
// cfg     | in  | cfg_we / cfg_wdata: static table entry count
//
// an error item passes the front's job register and the back's result register; a lookup
// steps through the stored keys in order, each with a registered ram read and a compare, and
// ends on the first hit, or on a miss with an insert (or a full status) after the last key
// arst_n clears the flow count, the offset and the queues; the key rams hold
// garbage until written and only entries below the flow count are compared
// the front can queue one new item while the back still searches; the result
// register holds a finished transfer until the sink takes it
`default_nettype none
module hpack_index_flow_tracker_core import hift_pkg::*; #(
	parameter int MaxFlows = MaxFlowsDefault
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	hift_if.sink            in_ch,
	hift_if.source          out_ch
);
	logic [7:0] static_q;
	logic       job_valid, job_ready;
	flow_job_t  job;

	// static table size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) static_q <= StaticEntriesReset;
		else if (cfg_we) static_q <= cfg_wdata;
	end

	// front: classify and form live key pair
	hift_front u_front (
		.clk(clk), .arst_n(arst_n), .static_entries(static_q),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .item(in_ch.data),
		.job_valid(job_valid), .job_ready(job_ready), .job(job));

	// back: search, insert and move the global offset
	hift_back #(.MaxFlows(MaxFlows)) u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(job_valid), .job_ready(job_ready), .job(job),
		.res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(out_ch.data));
endmodule
`default_nettype wire

>>> sim/hpack_index_flow_tracker_core_test.sv
// hpack_index_flow_tracker_core_test: self-checking bench for the header index flow tracker
// depends on hift_pkg, hift_if and hpack_index_flow_tracker_core
// directed table first, then random header blocks checked against a local flow predictor
`default_nettype none
module hpack_index_flow_tracker_core_test;
	import hift_pkg::*;

	// directed row: stimulus plus an optional typed-in expectation
	typedef struct {
		hdr_item_t item;
		bit        typed;
		flow_res_t res;
	} dir_row_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	hift_if #(.T(hdr_item_t)) in_if ();
	hift_if #(.T(flow_res_t)) out_if ();

	hpack_index_flow_tracker_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_if.sink),
		.out_ch    (out_if.source)
	);

	// predictor state: stored pairs in offset-free form
	logic [31:0] pair_first [MaxFlowsDefault];
	logic [31:0] pair_second [MaxFlowsDefault];
	int unsigned pairs_held;
	logic [31:0] live_offset;
	logic [7:0]  static_entries;

	flow_res_t   flow_res_q [$];  // results still to come, oldest first
	bit          typed_q [$];     // per offered item: typed expectation present
	flow_res_t   typed_res_q [$];
	int          failures;
	bit          long_hold;

	dir_row_t    dir_rows [$];

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// overall time limit
	initial begin
		#80_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic logic is_lookup_kind(logic [2:0] k);
		return (k == KIND_DYN) || (k == KIND_INC);
	endfunction

	// work out the result of one header block and advance the flow table
	function automatic flow_res_t track_flow(hdr_item_t it);
		flow_res_t   r;
		logic [2:0]  kinds [4];
		logic [15:0] idxs [4];
		logic [2:0]  sel_kind [2];
		logic [15:0] sel_idx [2];
		int          relevant;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] s;
		bit          found;
		r = '0;
		if (it.header_count < 8'd4) begin
			r.status = ST_FEW;
			return r;
		end
		kinds = '{it.kind_0, it.kind_1, it.kind_2, it.kind_3};
		idxs = '{it.index_0, it.index_1, it.index_2, it.index_3};
		sel_kind = '{KIND_STATIC, KIND_STATIC};
		sel_idx = '{16'd0, 16'd0};
		relevant = 0;
		for (int k = 0; k < 4; k++) begin
			if (kinds[k] == KIND_STATIC || kinds[k] == KIND_SKIP)
				continue;
			if (relevant < 2) begin
				sel_kind[relevant] = kinds[k];
				sel_idx[relevant] = idxs[k];
			end
			relevant++;
		end
		if (relevant != 2) begin
			r.status = ST_NOT_TWO;
			return r;
		end
		if (!is_lookup_kind(sel_kind[0])) begin
			r.status = ST_FIRST_BAD;
			return r;
		end
		if (!is_lookup_kind(sel_kind[1])) begin
			r.status = ST_SECOND_BAD;
			return r;
		end
		s = {24'd0, static_entries};
		// literals with incremental indexing insert before the lookup
		if (sel_kind[0] == KIND_DYN && sel_kind[1] == KIND_DYN) begin
			a = {16'd0, sel_idx[0]};
			b = {16'd0, sel_idx[1]};
		end else if (sel_kind[0] == KIND_DYN) begin
			live_offset += 32'd1;
			a = {16'd0, sel_idx[0]} + 32'd1;
			b = s + 32'd1;
		end else if (sel_kind[1] == KIND_DYN) begin
			live_offset += 32'd1;
			a = s + 32'd1;
			b = {16'd0, sel_idx[1]};
		end else begin
			live_offset += 32'd2;
			a = s + 32'd2;
			b = s + 32'd1;
		end
		a -= live_offset;
		b -= live_offset;
		found = 1'b0;
		for (int i = 0; i < pairs_held; i++) begin
			if (pair_first[i] == a && pair_second[i] == b) begin
				r.flow_id = i[7:0];
				found = 1'b1;
				break;
			end
		end
		if (!found) begin
			if (pairs_held >= MaxFlowsDefault) begin
				r.status = ST_FULL;
			end else begin
				pair_first[pairs_held] = a;
				pair_second[pairs_held] = b;
				r.flow_id = pairs_held[7:0];
				r.is_new = 1'b1;
				pairs_held++;
			end
		end
		if (it.header_count > 8'd4)
			live_offset += {24'd0, it.extra_inserts};
		return r;
	endfunction

	function automatic hdr_item_t mk(int cnt, int k0, int i0, int k1, int i1,
			int k2, int i2, int k3, int i3, int ex);
		hdr_item_t it;
		it.header_count = cnt[7:0];
		it.kind_0 = k0[2:0];
		it.index_0 = i0[15:0];
		it.kind_1 = k1[2:0];
		it.index_1 = i1[15:0];
		it.kind_2 = k2[2:0];
		it.index_2 = i2[15:0];
		it.kind_3 = k3[2:0];
		it.index_3 = i3[15:0];
		it.extra_inserts = ex[7:0];
		return it;
	endfunction

	function automatic flow_res_t res_of(int flow, int fresh, logic [2:0] st);
		flow_res_t r;
		r.flow_id = flow[7:0];
		r.is_new = fresh[0];
		r.status = st;
		return r;
	endfunction

	function automatic logic [2:0] rand_kind_for_lookup();
		return ($urandom_range(0, 1) == 0) ? KIND_DYN : KIND_INC;
	endfunction

	function automatic logic [2:0] rand_filler_kind();
		return ($urandom_range(0, 1) == 0) ? KIND_STATIC : KIND_SKIP;
	endfunction

	// random header block, mostly well formed so that lookups dominate
	function automatic hdr_item_t gen_header_block();
		hdr_item_t   it;
		int          pick;
		int          p0;
		int          p1;
		int          j;
		logic [31:0] la;
		logic [31:0] lb;
		logic [2:0]  kinds [4];
		logic [15:0] idxs [4];
		pick = $urandom_range(0, 99);
		it = hdr_item_t'({$urandom, $urandom, $urandom});
		if (pick < 8)
			return it; // pure noise, any kind code
		if (pick < 14) begin
			it.header_count = 8'($urandom_range(0, 3));
			return it;
		end
		it.header_count = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(4, 255)) : 8'd4;
		it.extra_inserts = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 251)) : 8'd0;
		if (pick < 40 && pairs_held > 0) begin
			// revisit a stored pair at its current live position
			j = $urandom_range(0, pairs_held - 1);
			la = pair_first[j] + live_offset;
			lb = pair_second[j] + live_offset;
			if (la < 32'h10000 && lb < 32'h10000) begin
				it.kind_0 = KIND_DYN;
				it.index_0 = la[15:0];
				it.kind_1 = KIND_DYN;
				it.index_1 = lb[15:0];
				it.kind_2 = rand_filler_kind();
				it.kind_3 = rand_filler_kind();
				return it;
			end
		end
		for (int k = 0; k < 4; k++) begin
			kinds[k] = rand_filler_kind();
			idxs[k] = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 15)) : 16'($urandom);
		end
		p0 = $urandom_range(0, 2);
		p1 = $urandom_range(p0 + 1, 3);
		kinds[p0] = rand_kind_for_lookup();
		kinds[p1] = rand_kind_for_lookup();
		if (pick < 50) begin
			// mostly broken: a third relevant field or an unsupported class
			if ($urandom_range(0, 1) == 0)
				kinds[$urandom_range(0, 3)] = 3'($urandom_range(4, 7));
			else
				kinds[$urandom_range(0, 3)] = KIND_DYN;
		end
		it.kind_0 = kinds[0];
		it.index_0 = idxs[0];
		it.kind_1 = kinds[1];
		it.index_1 = idxs[1];
		it.kind_2 = kinds[2];
		it.index_2 = idxs[2];
		it.kind_3 = kinds[3];
		it.index_3 = idxs[3];
		return it;
	endfunction

	// offer one header block and hold it until the transfer
	task automatic send_block(hdr_item_t it, bit typed, flow_res_t res);
		typed_q.insert(typed_q.size(), typed);
		typed_res_q.insert(typed_res_q.size(), res);
		in_if.valid = 1'b1;
		in_if.data = it;
		do @(posedge clk); while (!in_if.ready);
		@(negedge clk);
	endtask

	task automatic idle_input(int cycles);
		in_if.valid = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// random blocks in bursts with random gaps
	task automatic random_phase(int count);
		flow_res_t none;
		int burst;
		none = '0;
		while (count > 0) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && count > 0) begin
				send_block(gen_header_block(), 1'b0, none);
				burst--;
				count--;
			end
			if ($urandom_range(0, 3) != 0)
				idle_input($urandom_range(1, 20));
		end
		in_if.valid = 1'b0;
	endtask

	task automatic drain();
		in_if.valid = 1'b0;
		wait (flow_res_q.size() == 0);
		repeat (8) @(negedge clk);
	endtask

	// register write, only with the block idle
	task automatic set_static_entries(logic [7:0] v);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		static_entries = v;
		@(negedge clk);
	endtask

	// input transfer: predict, or take the typed-in expectation
	always @(posedge clk) begin
		flow_res_t pred;
		bit        typed;
		flow_res_t tres;
		if (arst_n && in_if.valid && in_if.ready) begin
			pred = track_flow(in_if.data);
			typed = typed_q.pop_front();
			tres = typed_res_q.pop_front();
			flow_res_q.insert(flow_res_q.size(), typed ? tres : pred);
		end
	end

	// output transfer: compare field by field with the oldest expectation
	always @(posedge clk) begin
		flow_res_t want;
		flow_res_t got;
		if (arst_n && out_if.valid && out_if.ready) begin
			got = out_if.data;
			if (flow_res_q.size() == 0) begin
				$display("%0t: unexpected result flow_id=%0d is_new=%0d status=%0d",
					$realtime, got.flow_id, got.is_new, got.status);
				failures++;
			end else begin
				want = flow_res_q.pop_front();
				if (got.flow_id !== want.flow_id) begin
					$display("%0t: flow_id expected %0d actual %0d",
						$realtime, want.flow_id, got.flow_id);
					failures++;
				end
				if (got.is_new !== want.is_new) begin
					$display("%0t: is_new expected %0d actual %0d",
						$realtime, want.is_new, got.is_new);
					failures++;
				end
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$realtime, want.status, got.status);
					failures++;
				end
			end
		end
	end

	// receiver: own stall pattern, with a long hold-off on request
	initial begin
		int hold;
		int stretch;
		out_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_if.ready = 1'b0;
				for (hold = 0; hold < 3000; hold++)
					@(negedge clk);
				long_hold = 1'b0;
			end
			stretch = $urandom_range(1, 40);
			case ($urandom_range(0, 2))
				0: begin
					out_if.ready = 1'b1;
					repeat (stretch) @(negedge clk);
				end
				1: begin
					repeat (stretch) begin
						out_if.ready = ($urandom_range(0, 2) != 0);
						@(negedge clk);
					end
				end
				default: begin
					out_if.ready = 1'b0;
					repeat ($urandom_range(1, 8)) @(negedge clk);
				end
			endcase
		end
	end

	initial begin
		flow_res_t none;
		none = '0;
		failures = 0;
		long_hold = 1'b0;
		pairs_held = 0;
		live_offset = '0;
		static_entries = StaticEntriesReset;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_if.valid = 1'b0;
		in_if.data = '0;

		// directed rows: errors, extremes and every pair rule
		dir_rows = '{
			'{mk(0, 1, 0, 1, 0, 0, 0, 0, 0, 0), 1, res_of(0, 0, ST_FEW)},
			'{mk(3, 1, 1, 1, 2, 0, 0, 0, 0, 251), 1, res_of(0, 0, ST_FEW)},
			'{mk(4, 0, 65535, 0, 0, 0, 0, 0, 0, 0), 1, res_of(0, 0, ST_NOT_TWO)},
			'{mk(4, 0, 0, 3, 7, 3, 9, 0, 0, 0), 1, res_of(0, 0, ST_NOT_TWO)},
			'{mk(4, 1, 1, 1, 2, 1, 3, 0, 0, 0), 1, res_of(0, 0, ST_NOT_TWO)},
			'{mk(4, 4, 1, 1, 2, 0, 0, 0, 0, 0), 1, res_of(0, 0, ST_FIRST_BAD)},
			'{mk(4, 1, 1, 7, 2, 0, 0, 3, 0, 0), 1, res_of(0, 0, ST_SECOND_BAD)},
			'{mk(4, 5, 1, 2, 2, 0, 0, 0, 0, 0), 1, res_of(0, 0, ST_FIRST_BAD)},
			'{mk(255, 1, 0, 0, 0, 6, 0, 0, 0, 9), 1, res_of(0, 0, ST_SECOND_BAD)},
			// first stored pair after reset, then a hit on it
			'{mk(4, 1, 0, 1, 0, 0, 0, 0, 0, 0), 1, res_of(0, 1, ST_OK)},
			'{mk(4, 1, 0, 1, 0, 3, 0, 0, 0, 251), 1, res_of(0, 0, ST_OK)},
			'{mk(255, 1, 65535, 1, 65535, 0, 0, 0, 0, 251), 0, none},
			'{mk(5, 1, 65535, 2, 0, 0, 0, 0, 0, 0), 0, none},
			'{mk(6, 2, 0, 1, 65535, 0, 0, 0, 0, 128), 0, none},
			'{mk(255, 2, 0, 2, 0, 0, 0, 0, 0, 128), 0, none},
			'{mk(4, 2, 0, 2, 0, 0, 0, 0, 0, 251), 0, none},
			'{mk(4, 0, 0, 3, 0, 1, 12, 2, 0, 0), 0, none},
			'{mk(7, 3, 0, 1, 43690, 3, 0, 1, 21845, 85), 0, none}
		};

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[r])
			send_block(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].res);
		drain();

		set_static_entries(8'd0);
		random_phase(400);
		drain();

		set_static_entries(8'd255);
		random_phase(400);

		// long receiver hold-off while blocks keep coming
		long_hold = 1'b1;
		random_phase(60);
		// sender pauses until every result is back
		drain();

		set_static_entries(8'($urandom));
		random_phase(500);
		drain();

		set_static_entries(StaticEntriesReset);
		random_phase(650);

		wait (flow_res_q.size() == 0);
		repeat (2 * MaxFlowsDefault + 50) @(negedge clk);
		if (flow_res_q.size() != 0) begin
			$display("%0t: %0d results never arrived", $realtime, flow_res_q.size());
			failures++;
		end
		if (failures == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
